// ----- rtl/isaac_random_generator_defines.svh -----
// assertion macros shared by the isaac generator modules
// no dependencies
`ifndef ISAAC_RANDOM_GENERATOR_DEFINES_SVH
`define ISAAC_RANDOM_GENERATOR_DEFINES_SVH

// implication checked on every rising clock edge outside reset
`define IRG_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// implication checked in the cycle after the antecedent
`define IRG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/irg_pkg.sv -----
// package for the isaac generator: commands, constants, queue word type
// no dependencies
package irg_pkg;
   localparam int unsigned SizeLog2Default = 4;
   localparam logic [31:0] Golden = 32'h9e3779b9;

   typedef enum logic [1:0] {
      FUNC_NEXT   = 2'd0,
      FUNC_SEED   = 2'd1,
      FUNC_INIT_S = 2'd2,
      FUNC_INIT_U = 2'd3
   } func_type;

   typedef struct packed {
      func_type    func;
      logic [3:0]  seed_index;
      logic [31:0] seed_value;
   } cmd_type;

   // half a scramble round over eight words, first four lines or last four lines
   function automatic logic [255:0] scramble_half(input logic [255:0] vin, input logic upper);
      logic [31:0] v [8];
      logic [255:0] r;
      for (int k = 0; k < 8; k++) v[k] = vin[32*k +: 32];
      if (!upper) begin
         v[0] ^= v[1] << 11; v[3] += v[0]; v[1] += v[2];
         v[1] ^= v[2] >> 2;  v[4] += v[1]; v[2] += v[3];
         v[2] ^= v[3] << 8;  v[5] += v[2]; v[3] += v[4];
         v[3] ^= v[4] >> 16; v[6] += v[3]; v[4] += v[5];
      end else begin
         v[4] ^= v[5] << 10; v[7] += v[4]; v[5] += v[6];
         v[5] ^= v[6] >> 4;  v[0] += v[5]; v[6] += v[7];
         v[6] ^= v[7] << 8;  v[1] += v[6]; v[7] += v[0];
         v[7] ^= v[0] >> 9;  v[2] += v[7]; v[0] += v[1];
      end
      for (int k = 0; k < 8; k++) r[32*k +: 32] = v[k];
      return r;
   endfunction
endpackage

// ----- rtl/isaac_random_generator.sv -----
// top level of the isaac random word generator
// depends on irg_pkg, irg_front, irg_engine
//
// channel   | ports                                   | direction
// request   | req_push req_full req_func req_seed_*   | in
// response  | rsp_empty rsp_pop rsp_random_value      | out
//
// next: with a word left the result goes through ST_OUT; otherwise a gen pass (ST_GSTA, ST_GEN) runs first
// seeded init: ST_PRE, fill over seed words then memory, gen pass; unseeded: ST_CLR, one fill pass
// init runs half a scramble round per cycle before the one-step gen loop
// seed write goes to the seed store from idle; a two-word command queue decouples request and engine
// a pending next waits while the result register is full
// reset is synchronous and clears the control state, result valid flag, stores, a, b, pc and queue count
module isaac_random_generator #(
   parameter int unsigned SIZE_LOG2 = irg_pkg::SizeLog2Default
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [1:0]  req_func,
   input  logic [3:0]  req_seed_index,
   input  logic [31:0] req_seed_value,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [31:0] rsp_random_value
);
   import irg_pkg::*;

   cmd_type req_cmd, cmd;
   logic    cmd_valid, cmd_take;

   always_comb begin
      req_cmd.func       = func_type'(req_func);
      req_cmd.seed_index = req_seed_index;
      req_cmd.seed_value = req_seed_value;
   end

   irg_front u_front (
      .clock, .reset, .req_push, .req_full, .req_cmd,
      .cmd_valid, .cmd_take, .cmd_out(cmd)
   );

   irg_engine #(.SIZE_LOG2(SIZE_LOG2)) u_engine (
      .clock, .reset, .cmd_valid, .cmd_take, .cmd_in(cmd),
      .rsp_empty, .rsp_pop, .rsp_random_value
   );
endmodule

// ----- rtl/irg_front.sv -----
// front end: two-entry command queue between the request port and the engine
// depends on irg_pkg
module irg_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  irg_pkg::cmd_type req_cmd,
   output logic             cmd_valid,
   input  logic             cmd_take,
   output irg_pkg::cmd_type cmd_out
);
   import irg_pkg::*;
   `include "isaac_random_generator_defines.svh"

   cmd_type    q_ff [2];
   cmd_type    q_in [2];
   logic [1:0] cnt_ff, cnt_in;
   logic       push_ok, pop_ok;

   assign req_full  = (cnt_ff == 2'd2);
   assign push_ok   = req_push && !req_full;
   assign cmd_valid = (cnt_ff != 2'd0);
   assign pop_ok    = cmd_take && cmd_valid;
   assign cmd_out   = q_ff[0];

   always_comb begin
      q_in[0] = q_ff[0];
      q_in[1] = q_ff[1];
      if (pop_ok) q_in[0] = q_ff[1];
      if (push_ok) begin
         if (cnt_ff == 2'd0 || (cnt_ff == 2'd1 && pop_ok)) q_in[0] = req_cmd;
         else q_in[1] = req_cmd;
      end
      cnt_in = cnt_ff + {1'b0, push_ok} - {1'b0, pop_ok};
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
      if (reset) cnt_ff <= 2'd0;
      else cnt_ff <= cnt_in;
   end

   `IRG_ASSERT_IMPL(a_cnt_range, clock, reset, 1'b1, cnt_ff != 2'd3, "queue count out of range")
   `IRG_ASSERT_NEXT(a_push_only, clock, reset, push_ok && !pop_ok, cnt_ff == $past(cnt_ff) + 2'd1,
      "push lost")
   `IRG_ASSERT_IMPL(a_pop_valid, clock, reset, pop_ok, cnt_ff != 2'd0, "pop from empty queue")
endmodule

// ----- rtl/irg_engine.sv -----
// back end: isaac state, init and generation sequencer, one-word result register
// depends on irg_pkg
module irg_engine #(
   parameter int unsigned SIZE_LOG2 = irg_pkg::SizeLog2Default
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_valid,
   output logic             cmd_take,
   input  irg_pkg::cmd_type cmd_in,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output logic [31:0]      rsp_random_value
);
   import irg_pkg::*;
   `include "isaac_random_generator_defines.svh"

   localparam int unsigned Rsiz = 1 << SIZE_LOG2;
   localparam int unsigned Groups = (Rsiz + 7) / 8;
   localparam int unsigned GW = (Groups > 1) ? $clog2(Groups) : 1;
   localparam int unsigned SizeHalf = Rsiz / 2;

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_PRE   = 7'b0000010,
      ST_FILL  = 7'b0000100,
      ST_GSTA  = 7'b0001000,
      ST_GEN   = 7'b0010000,
      ST_OUT   = 7'b0100000,
      ST_CLR   = 7'b1000000
   } state_type;

   state_type               state_ff, state_in;
   logic [31:0]             rs_ff [Rsiz];
   logic [31:0]             mm_ff [Rsiz];
   logic [31:0]             a_ff, b_ff, pc_ff;
   logic [SIZE_LOG2:0]      left_ff;
   logic [255:0]            v_ff;
   logic [2:0]              pre_ff;
   logic                    ph_ff;
   logic [GW-1:0]           grp_ff;
   logic                    pass2_ff, seeded_ff, after_gen_next_ff;
   logic [SIZE_LOG2-1:0]    i_ff;
   logic                    out_v_ff;
   logic [31:0]             out_ff;

   logic [255:0]            v_mix, v_src;
   logic [31:0]             x, sh, a_new, y, b_new, m_half, m_x, m_y;
   logic [SIZE_LOG2-1:0]    half_idx, x_idx, y_idx, grp_base, out_idx, seed_idx;
   logic                    need_gen;

   assign rsp_empty        = !out_v_ff;
   assign rsp_random_value = out_ff;
   assign cmd_take         = (state_ff == ST_IDLE) && cmd_valid &&
                             !(cmd_in.func == FUNC_NEXT && out_v_ff && !rsp_pop);
   assign need_gen         = (left_ff == '0) || (left_ff > (SIZE_LOG2+1)'(Rsiz));
   assign seed_idx         = (SIZE_LOG2)'(cmd_in.seed_index);

   // one generation step per cycle, memory write of y feeds the y lookup
   always_comb begin
      x = mm_ff[i_ff];
      unique case (i_ff[1:0])
         2'd0: sh = a_ff << 13;
         2'd1: sh = a_ff >> 6;
         2'd2: sh = a_ff << 2;
         default: sh = a_ff >> 16;
      endcase
      half_idx = i_ff + (SIZE_LOG2)'(SizeHalf);
      m_half   = mm_ff[half_idx];
      a_new    = (a_ff ^ sh) + m_half;
      x_idx    = x[SIZE_LOG2+1:2];
      m_x      = mm_ff[x_idx];
      y        = m_x + a_new + b_ff;
      y_idx    = y[2*SIZE_LOG2+1:SIZE_LOG2+2];
      m_y      = (y_idx == i_ff) ? y : mm_ff[y_idx];
      b_new    = m_y + x;
   end

   // fill group: when seeded, source words added with the first half round, second half next cycle
   always_comb begin
      grp_base = (SIZE_LOG2)'({grp_ff, 3'b000});
      v_src = v_ff;
      for (int k = 0; k < 8; k++) begin
         if (seeded_ff) begin
            if (!pass2_ff)
               v_src[32*k +: 32] = v_ff[32*k +: 32] + rs_ff[grp_base + (SIZE_LOG2)'(k)];
            else
               v_src[32*k +: 32] = v_ff[32*k +: 32] + mm_ff[grp_base + (SIZE_LOG2)'(k)];
         end
      end
      v_mix = ph_ff ? scramble_half(v_ff, 1'b1) : scramble_half(v_src, 1'b0);
   end

   assign out_idx = left_ff[SIZE_LOG2-1:0];

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_take) begin
               unique case (cmd_in.func)
                  FUNC_NEXT:   state_in = need_gen ? ST_GSTA : ST_OUT;
                  FUNC_SEED:   state_in = ST_IDLE;
                  FUNC_INIT_S: state_in = ST_PRE;
                  default:     state_in = ST_CLR;
               endcase
            end
         end
         ST_CLR:  state_in = ST_PRE;
         ST_PRE:  if (pre_ff == 3'd7) state_in = ST_FILL;
         ST_FILL: if (ph_ff && grp_ff == GW'(Groups-1) && (pass2_ff || !seeded_ff))
                     state_in = ST_GSTA;
         ST_GSTA: state_in = ST_GEN;
         ST_GEN:  if (i_ff == '1) state_in = after_gen_next_ff ? ST_OUT : ST_IDLE;
         ST_OUT:  state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // reset clears the stores and a, b, pc
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < Rsiz; k++) begin
            rs_ff[k] <= '0;
            mm_ff[k] <= '0;
         end
         a_ff <= '0; b_ff <= '0; pc_ff <= '0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (cmd_take) begin
                  after_gen_next_ff <= (cmd_in.func == FUNC_NEXT);
                  seeded_ff <= (cmd_in.func == FUNC_INIT_S);
                  pass2_ff  <= 1'b0;
                  pre_ff    <= 3'd0;
                  ph_ff     <= 1'b0;
                  grp_ff    <= '0;
                  v_ff      <= {8{Golden}};
                  if (cmd_in.func == FUNC_SEED)
                     rs_ff[seed_idx] <= cmd_in.seed_value;
                  if (cmd_in.func == FUNC_INIT_S || cmd_in.func == FUNC_INIT_U) begin
                     a_ff <= '0; b_ff <= '0; pc_ff <= '0;
                  end
               end
            end
            ST_CLR: for (int k = 0; k < Rsiz; k++) rs_ff[k] <= '0;
            ST_PRE: begin
               v_ff   <= scramble_half(v_ff, pre_ff[0]);
               pre_ff <= pre_ff + 3'd1;
            end
            ST_FILL: begin
               v_ff  <= v_mix;
               ph_ff <= !ph_ff;
               if (ph_ff) begin
                  for (int k = 0; k < 8; k++)
                     if (k < Rsiz) mm_ff[grp_base + (SIZE_LOG2)'(k)] <= v_mix[32*k +: 32];
                  if (grp_ff == GW'(Groups-1)) begin
                     grp_ff   <= '0;
                     pass2_ff <= 1'b1;
                  end else grp_ff <= grp_ff + GW'(1);
               end
            end
            ST_GSTA: begin
               pc_ff <= pc_ff + 32'd1;
               b_ff  <= b_ff + pc_ff + 32'd1;
               i_ff  <= '0;
            end
            ST_GEN: begin
               mm_ff[i_ff] <= y;
               rs_ff[i_ff] <= b_new;
               a_ff <= a_new;
               b_ff <= b_new;
               i_ff <= i_ff + (SIZE_LOG2)'(1);
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         out_v_ff <= 1'b0;
         left_ff  <= '0;
      end else begin
         state_ff <= state_in;
         if (rsp_pop && out_v_ff) out_v_ff <= 1'b0;
         if (state_ff == ST_IDLE && cmd_take) begin
            if (cmd_in.func == FUNC_NEXT)
               left_ff <= need_gen ? (SIZE_LOG2+1)'(Rsiz - 1) : left_ff - (SIZE_LOG2+1)'(1);
            else if (cmd_in.func != FUNC_SEED)
               left_ff <= (SIZE_LOG2+1)'(Rsiz);
         end
         if (state_ff == ST_OUT) begin
            out_v_ff <= 1'b1;
            out_ff   <= rs_ff[out_idx];
         end
      end
   end

   `IRG_ASSERT_IMPL(a_onehot, clock, reset, 1'b1, $onehot(state_ff), "state not one-hot")
   `IRG_ASSERT_IMPL(a_out_free, clock, reset, state_ff == ST_OUT, !out_v_ff || rsp_pop,
      "result register overwritten")
   `IRG_ASSERT_IMPL(a_left_range, clock, reset, 1'b1, left_ff <= (SIZE_LOG2+1)'(Rsiz),
      "words left out of range")
endmodule
